// ===== rtl/u8sd_pkg.sv =====
// Package for the UTF-8 stream decoder: word types, status codes and the
// classified-byte record passed from the front end to the back end.
// No dependencies.
package u8sd_pkg;

	localparam int unsigned FIELD_COUNT_BITS = 24;
	localparam int unsigned CP_BITS = 31;

	// Bits 30:11 of a value in the surrogate range 0xD800..0xDFFF.
	localparam logic [19:0] SURROGATE_HI = 20'h0001B;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEAD  = 2'd1,
		ST_SURROGATE = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [CP_BITS-1:0]          code_point;
		status_t                     status;
		logic [FIELD_COUNT_BITS-1:0] point_count;
		logic                        string_done;
	} out_item_t;

	// One input byte with both of its possible readings worked out.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       bad_lead;
		logic [2:0] lead_rem;
		logic [6:0] lead_val;
	} cls_item_t;

endpackage

// ===== rtl/u8sd_front.sv =====
// Front end of the UTF-8 stream decoder: takes input words and classifies
// each byte as a lead byte. Depends on u8sd_pkg.
module u8sd_front (
	input  logic                in_valid,
	output logic                in_ready,
	input  u8sd_pkg::in_item_t  in_item,
	input  logic                q_full,
	output logic                q_push,
	output u8sd_pkg::cls_item_t q_item
);
	import u8sd_pkg::*;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.data_byte = in_item.data_byte;
		q_item.last_byte = in_item.last_byte;
		q_item.bad_lead  = 1'b0;
		q_item.lead_rem  = 3'd0;
		q_item.lead_val  = 7'd0;
		priority casez (in_item.data_byte)
			8'b0???????: begin
				q_item.lead_val = in_item.data_byte[6:0];
			end
			8'b10??????: begin
				q_item.bad_lead = 1'b1;
			end
			8'b110?????: begin
				q_item.lead_rem = 3'd1;
				q_item.lead_val = {2'b0, in_item.data_byte[4:0]};
			end
			8'b1110????: begin
				q_item.lead_rem = 3'd2;
				q_item.lead_val = {3'b0, in_item.data_byte[3:0]};
			end
			8'b11110???: begin
				q_item.lead_rem = 3'd3;
				q_item.lead_val = {4'b0, in_item.data_byte[2:0]};
			end
			8'b111110??: begin
				q_item.lead_rem = 3'd4;
				q_item.lead_val = {5'b0, in_item.data_byte[1:0]};
			end
			8'b1111110?: begin
				q_item.lead_rem = 3'd5;
				q_item.lead_val = {6'b0, in_item.data_byte[0]};
			end
			default: begin
				q_item.bad_lead = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/u8sd_queue.sv =====
// Two-entry queue of classified bytes between the decoder's front and back
// ends. Depends on u8sd_pkg.
module u8sd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8sd_pkg::cls_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                avail,
	output u8sd_pkg::cls_item_t head_item
);
	import u8sd_pkg::*;

	cls_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign avail     = (count_q != 2'd0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/u8sd_back.sv =====
// Back end of the UTF-8 stream decoder: sequence state, code point assembly,
// error handling and the output register. Depends on u8sd_pkg.
module u8sd_back #(
	parameter int unsigned COUNT_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_avail,
	input  u8sd_pkg::cls_item_t q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output u8sd_pkg::out_item_t out_item
);
	import u8sd_pkg::*;

	localparam int unsigned CW = (COUNT_BITS < FIELD_COUNT_BITS) ? COUNT_BITS
	                                                              : FIELD_COUNT_BITS;

	logic [2:0]         rem_q;
	logic [CP_BITS-1:0] acc_q;
	logic [CW-1:0]      total_q;
	logic               disc_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               bad;
	logic [2:0]         rem_n;
	logic [CP_BITS-1:0] acc_n;
	logic [CW-1:0]      total_inc;
	logic               emit;
	out_item_t          res;
	logic [2:0]         rem_d;
	logic [CP_BITS-1:0] acc_d;
	logic [CW-1:0]      total_d;
	logic               disc_d;

	assign q_pop     = q_avail && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign total_inc = (&total_q) ? total_q : total_q + 1'b1;

	always_comb begin
		if (rem_q == 3'd0) begin
			bad   = q_item.bad_lead;
			rem_n = q_item.lead_rem;
			acc_n = CP_BITS'(q_item.lead_val);
		end else begin
			bad   = 1'b0;
			rem_n = rem_q - 3'd1;
			acc_n = {acc_q[CP_BITS-7:0], q_item.data_byte[5:0]};
		end
	end

	always_comb begin
		emit            = 1'b0;
		res.code_point  = '0;
		res.status      = ST_OK;
		res.point_count = FIELD_COUNT_BITS'(total_q);
		res.string_done = q_item.last_byte;
		rem_d           = rem_q;
		acc_d           = acc_q;
		total_d         = total_q;
		disc_d          = disc_q;
		priority if (disc_q) begin
			// Dropping the rest of a string after an error.
		end else if (bad || (rem_n == 3'd0 && acc_n[CP_BITS-1:11] == SURROGATE_HI)) begin
			emit       = 1'b1;
			res.status = bad ? ST_BAD_LEAD : ST_SURROGATE;
			rem_d      = 3'd0;
			acc_d      = '0;
			disc_d     = 1'b1;
		end else if (rem_n != 3'd0) begin
			rem_d = rem_n;
			acc_d = acc_n;
			if (q_item.last_byte) begin
				emit       = 1'b1;
				res.status = ST_TRUNCATED;
			end
		end else begin
			emit            = 1'b1;
			res.code_point  = acc_n;
			res.point_count = FIELD_COUNT_BITS'(total_inc);
			rem_d           = 3'd0;
			acc_d           = '0;
			total_d         = total_inc;
		end
		// The end of a string returns all state to zero.
		if (q_item.last_byte) begin
			rem_d   = 3'd0;
			acc_d   = '0;
			total_d = '0;
			disc_d  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= 3'd0;
			acc_q       <= '0;
			total_q     <= '0;
			disc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				rem_q       <= rem_d;
				acc_q       <= acc_d;
				total_q     <= total_d;
				disc_q      <= disc_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front end, queue and back end.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back.
//
// Usage: one UTF-8 byte enters per input word on in_valid/in_ready, with
// last_byte marking the final byte of a string. Each completed code point
// leaves as one output word on out_valid/out_ready with a saturating count
// of the points decoded so far in the string. A bad lead byte, a surrogate
// or a string that ends inside a sequence gives one error word with a zero
// code point; the remaining bytes of that string then give no words.
// A byte that neither completes a point nor shows an error gives no word.
// Throughput is one byte per cycle while the output is not stalled. An
// accepted byte is written into the queue, and from the head of the queue
// the sequence unit decodes it into the output register.
// The two-entry queue takes bytes while the output word waits; when the
// receiver stalls, it fills and in_ready drops after at most two more bytes.
// Reset empties the queue and the output register and clears all string
// state; the block is ready as soon as reset is released.
module utf8_stream_decoder #(
	parameter int unsigned COUNT_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  u8sd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output u8sd_pkg::out_item_t out_item
);
	import u8sd_pkg::*;

	cls_item_t push_item;
	cls_item_t head_item;
	logic      push;
	logic      pop;
	logic      full;
	logic      avail;

	u8sd_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (full),
		.q_push   (push),
		.q_item   (push_item)
	);

	u8sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.avail     (avail),
		.head_item (head_item)
	);

	u8sd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (avail),
		.q_item    (head_item),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/u8sd_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, attached by bind.
// Depends on u8sd_pkg and utf8_stream_decoder.
module u8sd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input u8sd_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input u8sd_pkg::out_item_t out_item
);
	import u8sd_pkg::*;

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output word changed while stalled");

	// Error words carry no code point.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_OK |-> out_item.code_point == '0)
		else $error("error word with nonzero code point");

	// Truncation is only found at the end of a string.
	a_trunc_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_TRUNCATED |-> out_item.string_done)
		else $error("truncated word without string end");

	// A decoded point is always counted.
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_OK |-> out_item.point_count != '0)
		else $error("decoded point with zero count");

	// An offered input word holds until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("input word changed while stalled");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);
